/* rtl/core/young_tableau_extract_min_macros.svh */
// Assertion macros used by the young tableau top level.
`ifndef YOUNG_TABLEAU_EXTRACT_MIN_MACROS_SVH
`define YOUNG_TABLEAU_EXTRACT_MIN_MACROS_SVH

// same-cycle implication
`define YTEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("young tableau check failed");

// next-cycle implication
`define YTEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("young tableau check failed");

`endif

/* rtl/core/ytem_pkg.sv */
// Types and constants of the young tableau extract-min block.
package ytem_pkg;

	localparam logic signed [15:0] EMPTY_MARK = 16'sd9999;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [15:0] min_value;
		logic               empty_res;
	} res_word_t;

	typedef struct packed {
		logic               stop;
		logic               take_down;
		logic signed [15:0] mv;
	} sift_dec_t;

endpackage

/* rtl/core/ytem_sift_cmp.sv */
// Sift step decision: picks the neighbor that moves into the hole.
module ytem_sift_cmp
	import ytem_pkg::*;
(
	input  logic signed [15:0] down_raw,
	input  logic signed [15:0] right_raw,
	input  logic               down_out,
	input  logic               right_out,
	output sift_dec_t          dec
);

	logic signed [15:0] down_v;
	logic signed [15:0] right_v;
	logic               both_empty;
	logic               take_down;

	assign down_v     = down_out  ? EMPTY_MARK : down_raw;
	assign right_v    = right_out ? EMPTY_MARK : right_raw;
	assign both_empty = (down_v == EMPTY_MARK) && (right_v == EMPTY_MARK);
	// tie goes right
	assign take_down  = down_v < right_v;

	assign dec.take_down = take_down;
	assign dec.mv        = take_down ? down_v : right_v;
	assign dec.stop      = both_empty || (take_down ? down_out : right_out);

endmodule

/* rtl/core/young_tableau_extract_min.sv */
// Young tableau with write and extract-min commands: top level.
//
// Command channel cmd_valid/cmd_ready/cmd_word: cmd write stores value at
// (row, col) and gives no result; cmd extract returns the top-left value and
// sinks the hole toward the bottom-right. Result channel res_valid/res_ready/
// res_word carries min_value and empty_res for each extract.
// Config port cfg_we/cfg_index/cfg_data sets rows and columns in use; write
// it only while the block is idle.
// A write is stored as it is accepted. An extract runs head, sift and finish
// steps, with k hole moves in the sift (at most rows + cols - 2 in use); a zero
// size skips to the finish step. The rate is set by the sift loop: one
// hole move per cycle, both neighbors read from the two read ports of the
// cell memory, compared by one shared compare unit, and the hole written back.
// cmd_ready is high only while no extract is in progress.
// A finished result waits in an output register; a new command is taken while
// it waits, and a following extract holds in its last step until the slot
// frees. Reset clears control and sets both sizes to 16; cell contents are
// undefined until written.
`include "young_tableau_extract_min_macros.svh"

module young_tableau_extract_min
	import ytem_pkg::*;
#(
	parameter int ROWS = 16,
	parameter int COLS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_word_t             cmd_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_word_t             res_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIW   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int RCW   = ($clog2(ROWS + 1) > CFG_DATA_W) ? $clog2(ROWS + 1) : CFG_DATA_W;
	localparam int CCW   = ($clog2(COLS + 1) > CFG_DATA_W) ? $clog2(COLS + 1) : CFG_DATA_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	function automatic logic [AW-1:0] cell_addr(input int r, input int c);
		logic [AW-1:0] a;
		a = '0;
		if (r < ROWS && c < COLS) begin
			a = AW'(r * COLS + c);
		end
		return a;
	endfunction

	logic [1:0]            state_q;
	logic [CFG_DATA_W-1:0] rows_q;
	logic [CFG_DATA_W-1:0] cols_q;
	logic [RIW-1:0]        r_q;
	logic [CIW-1:0]        c_q;
	logic signed [15:0]    min_q;
	logic                  res_valid_q;
	res_word_t             res_q;

	logic signed [15:0]    mem_q [DEPTH];
	logic signed [15:0]    rd_a_q;
	logic signed [15:0]    rd_b_q;
	logic                  down_out_q;
	logic                  right_out_q;

	logic [RCW-1:0]        nr_eff;
	logic [CCW-1:0]        nc_eff;
	logic [RIW-1:0]        lr;
	logic [CIW-1:0]        lc;
	logic                  down_out_nx;
	logic                  right_out_nx;
	logic [AW-1:0]         rd_a_addr;
	logic [AW-1:0]         rd_b_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic signed [15:0]    wr_data;
	logic                  res_load;
	logic                  cmd_acc;
	sift_dec_t             dec;

	ytem_sift_cmp u_cmp (
		.down_raw  (rd_a_q),
		.right_raw (rd_b_q),
		.down_out  (down_out_q),
		.right_out (right_out_q),
		.dec       (dec)
	);

	assign nr_eff = (RCW'(rows_q) > RCW'(ROWS)) ? RCW'(ROWS) : RCW'(rows_q);
	assign nc_eff = (CCW'(cols_q) > CCW'(COLS)) ? CCW'(COLS) : CCW'(cols_q);

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign res_load  = (state_q == S_FIN) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	// position whose neighbors are fetched this cycle
	always_comb begin
		lr = '0;
		lc = '0;
		if (state_q == S_CMP) begin
			lr = r_q;
			lc = c_q;
			if (!dec.stop) begin
				if (dec.take_down) begin
					lr = r_q + RIW'(1);
				end else begin
					lc = c_q + CIW'(1);
				end
			end
		end
	end

	assign down_out_nx  = (RCW'(lr) + RCW'(1)) >= nr_eff;
	assign right_out_nx = (CCW'(lc) + CCW'(1)) >= nc_eff;
	assign rd_a_addr    = (state_q == S_IDLE) ? '0 : cell_addr(int'(lr) + 1, int'(lc));
	assign rd_b_addr    = cell_addr(int'(lr), int'(lc) + 1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cell_addr(int'(r_q), int'(c_q));
		wr_data = dec.stop ? EMPTY_MARK : dec.mv;
		if (state_q == S_IDLE) begin
			wr_en   = cmd_acc && (cmd_word.cmd == CMD_WRITE) &&
			          (int'(cmd_word.row) < ROWS) && (int'(cmd_word.col) < COLS);
			wr_addr = cell_addr(int'(cmd_word.row), int'(cmd_word.col));
			wr_data = cmd_word.value;
		end else if (state_q == S_CMP) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q      <= mem_q[rd_a_addr];
		rd_b_q      <= mem_q[rd_b_addr];
		down_out_q  <= down_out_nx;
		right_out_q <= right_out_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= CFG_DATA_W'(16);
			cols_q      <= CFG_DATA_W'(16);
			r_q         <= '0;
			c_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= cfg_data;
					CFG_COLS: cols_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc && cmd_word.cmd == CMD_EXTRACT) begin
						r_q <= '0;
						c_q <= '0;
						if (nr_eff == '0 || nc_eff == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (dec.stop) begin
						state_q <= S_FIN;
					end else begin
						r_q <= lr;
						c_q <= lc;
					end
				end
				S_FIN: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			min_q <= EMPTY_MARK;
		end else if (state_q == S_HEAD) begin
			min_q <= rd_a_q;
		end
		if (res_load) begin
			res_q.min_value <= min_q;
			res_q.empty_res <= (min_q == EMPTY_MARK);
		end
	end

	`YTEM_ASSERT_NEXT(a_hole_one_move, clk, arst_n, (state_q == S_CMP) && !dec.stop, (r_q != $past(r_q)) != (c_q != $past(c_q)))
	`YTEM_ASSERT_NOW(a_head_at_origin, clk, arst_n, state_q == S_HEAD, (r_q == '0) && (c_q == '0))
	`YTEM_ASSERT_NOW(a_result_from_fin, clk, arst_n, $rose(res_valid_q), $past(state_q) == S_FIN)

endmodule

/* dv/tb_young_tableau_extract_min.sv */
// Testbench for young_tableau_extract_min: random sorted fills, extracts and checks against a predictor.
`timescale 1ns / 1ps

module tb_young_tableau_extract_min
	import ytem_pkg::*;
;

	localparam int TAB_ROWS     = 16;
	localparam int TAB_COLS     = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int SETTLE       = 40;
	localparam int LONG_HOLD    = 400;
	localparam int LIMIT        = 1000000;

	class tableau_scoreboard;
		logic signed [15:0] cells [0:TAB_ROWS*TAB_COLS-1];
		logic [4:0] rows_cfg;
		logic [4:0] cols_cfg;
		res_word_t min_q [$];
		int errors;

		function new();
			rows_cfg = 5'd16;
			cols_cfg = 5'd16;
			errors = 0;
		endfunction

		function void set_sizes(logic [4:0] nr, logic [4:0] nc);
			rows_cfg = nr;
			cols_cfg = nc;
		endfunction

		function int pending();
			return min_q.size();
		endfunction

		function void note_command(cmd_word_t w);
			int nr, nc, r, c, tr, tc;
			logic signed [15:0] minv, down, right, mv;
			res_word_t res;
			if (w.cmd == CMD_WRITE) begin
				cells[int'(w.row) * TAB_COLS + int'(w.col)] = w.value;
				return;
			end
			nr = (rows_cfg > TAB_ROWS) ? TAB_ROWS : int'(rows_cfg);
			nc = (cols_cfg > TAB_COLS) ? TAB_COLS : int'(cols_cfg);
			minv = EMPTY_MARK;
			if (nr != 0 && nc != 0) begin
				minv = cells[0];
				cells[0] = EMPTY_MARK;
				r = 0;
				c = 0;
				for (int s = 0; s < TAB_ROWS + TAB_COLS; s++) begin
					down = (r + 1 < nr) ? cells[(r + 1) * TAB_COLS + c] : EMPTY_MARK;
					right = (c + 1 < nc) ? cells[r * TAB_COLS + c + 1] : EMPTY_MARK;
					if (down == EMPTY_MARK && right == EMPTY_MARK)
						break;
					if (down < right) begin
						tr = r + 1;
						tc = c;
						mv = down;
					end else begin
						tr = r;
						tc = c + 1;
						mv = right;
					end
					if (tr >= nr || tc >= nc)
						break;
					cells[r * TAB_COLS + c] = mv;
					cells[tr * TAB_COLS + tc] = EMPTY_MARK;
					r = tr;
					c = tc;
				end
			end
			res.min_value = minv;
			res.empty_res = (minv == EMPTY_MARK);
			min_q.push_back(res);
		endfunction

		function void check_result(res_word_t got);
			res_word_t want;
			if (min_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got min_value %0d empty_res %0b",
					$time, got.min_value, got.empty_res);
				errors++;
				return;
			end
			want = min_q.pop_front();
			if (got.min_value !== want.min_value) begin
				$display("%0t: min_value mismatch, expected %0d, got %0d",
					$time, want.min_value, got.min_value);
				errors++;
			end
			if (got.empty_res !== want.empty_res) begin
				$display("%0t: empty_res mismatch, expected %0b, got %0b",
					$time, want.empty_res, got.empty_res);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_word_t cmd_word = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_word_t res_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int cycles = 0;
	int items_sent = 0;
	tableau_scoreboard board = new();

	young_tableau_extract_min #(
		.ROWS(TAB_ROWS),
		.COLS(TAB_COLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word(res_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// gaps: mostly none or short, a few long, none at all in every fourth window
	function automatic int pick_gap();
		int r;
		if ((cycles / 1024) % 4 == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return -32768;
		if (r == 1)
			return 9999;
		return $urandom_range(0, 42767) - 32768;
	endfunction

	function automatic cmd_word_t write_word(int r, int c, int v);
		cmd_word_t w;
		w.cmd = CMD_WRITE;
		w.row = 4'(r);
		w.col = 4'(c);
		w.value = 16'(v);
		return w;
	endfunction

	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (!cmd_ready);
		board.note_command(w);
		items_sent++;
	endtask

	task automatic put_cell(int r, int c, int v);
		send_word(write_word(r, c, v));
	endtask

	task automatic take_min();
		cmd_word_t w;
		w = cmd_word_t'($bits(cmd_word_t)'($urandom));
		w.cmd = CMD_EXTRACT;
		send_word(w);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_sizes(int nr, int nc);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data <= 5'(nr);
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= 5'(nc);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_sizes(5'(nr), 5'(nc));
	endtask

	// sorted fill: each cell at least its upper and left neighbors, tail cut to empty
	task automatic fill_region(int er, int ec);
		int grid [0:TAB_ROWS-1][0:TAB_COLS-1];
		int r, c, k, v, span, cut, base;
		bit backward;
		case ($urandom_range(0, 2))
			0: span = 3;
			1: span = 100;
			default: span = 3000;
		endcase
		cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 42766) - 32768 : 9999;
		base = ($urandom_range(0, 3) == 0) ? -32768 : $urandom_range(0, 40000) - 32768;
		for (r = 0; r < er; r++) begin
			for (c = 0; c < ec; c++) begin
				if (r == 0 && c == 0)
					v = base;
				else if (r == 0)
					v = grid[r][c-1];
				else if (c == 0)
					v = grid[r-1][c];
				else
					v = (grid[r-1][c] > grid[r][c-1]) ? grid[r-1][c] : grid[r][c-1];
				v = v + $urandom_range(0, span);
				if (v >= 9999 || v > cut)
					v = 9999;
				grid[r][c] = v;
			end
		end
		backward = $urandom_range(0, 1);
		for (int i = 0; i < er * ec; i++) begin
			k = backward ? er * ec - 1 - i : i;
			r = k / ec;
			c = k % ec;
			put_cell(r, c, grid[r][c]);
		end
	endtask

	task automatic run_phase(int nr, int nc);
		int er, ec, n;
		er = (nr > TAB_ROWS) ? TAB_ROWS : nr;
		ec = (nc > TAB_COLS) ? TAB_COLS : nc;
		wait_idle();
		set_sizes(nr, nc);
		fill_region(er, ec);
		n = er * ec + $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15)
				put_cell($urandom_range(0, 15), $urandom_range(0, 15), rand_value());
			take_min();
		end
	endtask

	initial begin
		int fixed_r [7];
		int fixed_c [7];
		int start, nr, nc;
		fixed_r = '{16, 1, 16, 31, 2, 0, 7};
		fixed_c = '{16, 16, 1, 3, 31, 5, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait_idle();
		set_sizes(2, 2);
		put_cell(0, 0, -32768);
		put_cell(0, 1, 5);
		put_cell(1, 0, 5);
		put_cell(1, 1, 9999);
		put_cell(15, 15, -1);
		put_cell(15, 0, 0);
		take_min();
		take_min();
		take_min();
		take_min();
		take_min();
		put_cell(0, 0, 0);
		put_cell(0, 1, 0);
		take_min();
		take_min();
		wait_idle();
		set_sizes(0, 16);
		take_min();
		put_cell(0, 0, 7);
		take_min();
		wait_idle();
		set_sizes(2, 0);
		take_min();

		start = items_sent;
		foreach (fixed_r[i])
			run_phase(fixed_r[i], fixed_c[i]);
		while (items_sent - start < RANDOM_ITEMS) begin
			nr = $urandom_range(1, 5);
			nc = $urandom_range(1, 5);
			case ($urandom_range(0, 9))
				0: nr = ($urandom_range(0, 1) == 0) ? 16 : 31;
				1: nc = ($urandom_range(0, 1) == 0) ? 0 : 16;
				default: ;
			endcase
			run_phase(nr, nc);
		end

		wait_idle();
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		int stall_left;
		int got;
		stall_left = 0;
		got = 0;
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				board.check_result(res_word);
				got++;
				if (got == 30 || got == 300)
					stall_left = LONG_HOLD;
			end
			if (stall_left == 0 && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule

/* young_tableau_extract_min.f */
+incdir+rtl/core
rtl/core/ytem_pkg.sv
rtl/core/ytem_sift_cmp.sv
rtl/core/young_tableau_extract_min.sv
dv/tb_young_tableau_extract_min.sv
